@@ hw/rtl/dqcs_pkg.sv @@
// Shared types and widths for the dashed quadratic curve segmenter.
// No dependencies; imported by every module of the block.
`default_nettype none

package dqcs_pkg;

  // Coordinate width, 1/16 pixel, two's complement
  localparam int COORD_W = 20;

  // Shared multiplier: signed operands and full signed product
  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;

  // Squared distance and its integer root
  localparam int SQ_W   = 42;
  localparam int ROOT_W = 21;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic            go;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/dashed_quadratic_curve_segmenter_core.sv @@
// Dashed quadratic curve segmenter: sequencer around one shared multiplier.
// Depends on dqcs_pkg, dqcs_mul and dqcs_isqrt.
//
//   channel   handshake              payload
//   request   start, busy            start_x, start_y, end_x, end_y
//   chord     seg_valid (1 cycle)    seg_x0, seg_y0, seg_x1, seg_y1, last_segment
//
// A request is taken when start is high and busy is low; busy stays high
// until the closing chord is issued. Setup forms the squares, waits for the
// root and derives the step; every curve sample then runs through phases on
// the shared multiplier (t^2, four partial products, the y term and a divide
// by ten as a reciprocal product), and a closing chord follows at the end.
// There are n = floor(65536/step) + 1 samples (20 to 101) per request.
// Chords are shown for exactly one cycle each; the receiver cannot stall.
// rst is synchronous.
`default_nettype none

module dashed_quadratic_curve_segmenter_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [dqcs_pkg::COORD_W-1:0]      start_x,
  input  logic signed [dqcs_pkg::COORD_W-1:0]      start_y,
  input  logic signed [dqcs_pkg::COORD_W-1:0]      end_x,
  input  logic signed [dqcs_pkg::COORD_W-1:0]      end_y,
  output logic                                     seg_valid,
  output logic signed [dqcs_pkg::COORD_W-1:0]      seg_x0,
  output logic signed [dqcs_pkg::COORD_W-1:0]      seg_y0,
  output logic signed [dqcs_pkg::COORD_W-1:0]      seg_x1,
  output logic signed [dqcs_pkg::COORD_W-1:0]      seg_y1,
  output logic                                     last_segment
);
  import dqcs_pkg::*;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [11:0] STEP_MIN   = 12'd655;
  localparam logic [14:0] D_LIMIT    = 15'd20000;
  localparam logic [23:0] STEP_BIAS  = 24'd1562;       // 200000 / 128
  localparam logic [MUL_W-1:0] M_STEP = 30'd21990233;  // ceil(2^36 / 3125)
  localparam logic [MUL_W-1:0] M_TEN  = 30'd214748365; // ceil(2^31 / 10)
  localparam logic [53:0] X_HALF     = 54'd2147483648; // 2^31
  localparam logic [57:0] Y_HALF     = 58'd21474836480; // 5 * 2^32
  localparam logic [25:0] Y_BIAS     = 26'd41943040;   // 10 * 2^22
  localparam logic [5:0]  MAX_CHORDS = 6'd51;

  // Per-sample phase codes
  localparam logic [3:0] PH_SQR  = 4'd0;
  localparam logic [3:0] PH_LIN  = 4'd1;
  localparam logic [3:0] PH_XH   = 4'd2;
  localparam logic [3:0] PH_XL   = 4'd3;
  localparam logic [3:0] PH_YH   = 4'd4;
  localparam logic [3:0] PH_YL   = 4'd5;
  localparam logic [3:0] PH_YS   = 4'd6;
  localparam logic [3:0] PH_NORM = 4'd7;
  localparam logic [3:0] PH_DIV  = 4'd8;
  localparam logic [3:0] PH_OUT  = 4'd9;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQA   = 9'b000000010,
    S_SQB   = 9'b000000100,
    S_SQC   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_STEPM = 9'b000100000,
    S_STEPS = 9'b001000000,
    S_POINT = 9'b010000000,
    S_LAST  = 9'b100000000
  } state_t;

  state_t state;

  // Request operands and derived terms
  logic signed [COORD_W-1:0] sx, sy, ex, ey;
  logic signed [COORD_W:0]   dx, dy, dxe;
  logic signed [23:0]        ey11, gy;

  // Setup
  logic [40:0] sq_lo;
  logic [23:0] nprime;
  logic        far;
  logic [11:0] step;

  // Sample loop
  logic [16:0]         t;
  logic [16:0]         t_next;
  logic [3:0]          ph;
  logic                skip;
  logic [5:0]          count;
  logic [COORD_W-1:0]  px, py, cx, cy_w;
  logic [32:0]         tsq;
  logic [53:0]         acc_x, xr;
  logic [57:0]         acc_y, yr;
  logic [25:0]         ny;
  logic [11:0]         s_raw;
  logic [14:0]         dgap;

  // Shared units
  mul_op_t                   op;
  logic signed [PROD_W-1:0]  prod;
  sqrt_req_t                 sq_req;
  sqrt_rsp_t                 sq_rsp;

  dqcs_mul u_mul (
    .clk  (clk),
    .op   (op),
    .prod (prod)
  );

  dqcs_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  assign busy = (state != S_IDLE);

  // Rounding and scaling of accumulated terms, plus next t, raw step and distance gap
  always_comb begin
    xr     = acc_x + X_HALF;
    yr     = acc_y + Y_HALF;
    cy_w   = sy + prod[50:31];
    t_next = t + 17'(step);
    s_raw  = prod[47:36];
    dgap   = D_LIMIT - sq_rsp.root[14:0];
  end

  // Root request: squared distance formed as dy^2 arrives
  always_comb begin
    sq_req.go       = (state == S_SQC);
    sq_req.radicand = {1'b0, sq_lo} + {1'b0, prod[40:0]};
  end

  // Multiplier operand select
  always_comb begin
    op.a = '0;
    op.b = '0;
    case (state)
      S_SQA: begin
        op.a = MUL_W'(dx);
        op.b = MUL_W'(dx);
      end
      S_SQB: begin
        op.a = MUL_W'(dy);
        op.b = MUL_W'(dy);
      end
      S_STEPM: begin
        op.a = MUL_W'(nprime);
        op.b = M_STEP;
      end
      S_POINT: begin
        case (ph)
          PH_SQR: begin
            op.a = MUL_W'(t);
            op.b = MUL_W'(t);
          end
          PH_LIN: begin
            op.a = MUL_W'(gy);
            op.b = MUL_W'(t);
          end
          PH_XH: begin
            op.a = MUL_W'(dxe);
            op.b = MUL_W'(tsq[32:16]);
          end
          PH_XL: begin
            op.a = MUL_W'(dxe);
            op.b = MUL_W'(tsq[15:0]);
          end
          PH_YH: begin
            op.a = MUL_W'(ey11);
            op.b = MUL_W'(tsq[32:16]);
          end
          PH_YL: begin
            op.a = MUL_W'(ey11);
            op.b = MUL_W'(tsq[15:0]);
          end
          PH_DIV: begin
            op.a = MUL_W'(ny);
            op.b = M_TEN;
          end
          default: begin
            op.a = '0;
            op.b = '0;
          end
        endcase
      end
      default: begin
        op.a = '0;
        op.b = '0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_valid <= 1'b0;
    end else begin
      seg_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SQA;
          end
        end
        S_SQA:   state <= S_SQB;
        S_SQB:   state <= S_SQC;
        S_SQC:   state <= S_ROOT;
        S_ROOT: begin
          if (sq_rsp.done) begin
            state <= S_STEPM;
          end
        end
        S_STEPM: state <= S_STEPS;
        S_STEPS: state <= S_POINT;
        S_POINT: begin
          if (ph == PH_OUT) begin
            if (!skip && count < MAX_CHORDS) begin
              seg_valid <= 1'b1;
            end
            if (t_next > ONE_Q16) begin
              state <= S_LAST;
            end
          end
        end
        S_LAST: begin
          seg_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sx   <= start_x;
        sy   <= start_y;
        ex   <= end_x;
        ey   <= end_y;
        dx   <= 21'(start_x) - 21'(end_x);
        dy   <= 21'(start_y) - 21'(end_y);
        dxe  <= 21'(end_x) - 21'(start_x);
        ey11 <= (24'(end_y) <<< 3) + (24'(end_y) <<< 1) + 24'(end_y);
        gy   <= (24'(start_y) <<< 3) + (24'(start_y) <<< 1) + 24'(end_y);
      end
      S_SQB: begin
        sq_lo <= prod[40:0];
      end
      S_ROOT: begin
        far    <= (sq_rsp.root >= ROOT_W'(D_LIMIT));
        nprime <= {dgap, 9'b0} + STEP_BIAS;
      end
      S_STEPS: begin
        if (far || s_raw < STEP_MIN) begin
          step <= STEP_MIN;
        end else begin
          step <= s_raw;
        end
        t     <= '0;
        ph    <= PH_SQR;
        skip  <= 1'b0;
        count <= '0;
        px    <= sx;
        py    <= sy;
      end
      S_POINT: begin
        case (ph)
          PH_LIN: begin
            tsq <= prod[32:0];
          end
          PH_XH: begin
            acc_y <= 58'd0 - {prod[41:0], 16'b0};
          end
          PH_XL: begin
            acc_x <= {prod[37:0], 16'b0};
          end
          PH_YH: begin
            acc_x <= acc_x + prod[53:0];
          end
          PH_YL: begin
            acc_y <= acc_y + {prod[41:0], 16'b0};
          end
          PH_YS: begin
            acc_y <= acc_y + prod[57:0];
            cx    <= sx + xr[51:32];
          end
          PH_NORM: begin
            ny <= yr[57:32] + Y_BIAS;
          end
          PH_OUT: begin
            // Every other chord, capped at the chord budget
            if (!skip && count < MAX_CHORDS) begin
              seg_x0       <= px;
              seg_y0       <= py;
              seg_x1       <= cx;
              seg_y1       <= cy_w;
              last_segment <= 1'b0;
              count        <= count + 1'b1;
            end
            skip <= !skip;
            px   <= cx;
            py   <= cy_w;
            t    <= t_next;
          end
          default: begin
          end
        endcase
        if (ph == PH_OUT) begin
          ph <= PH_SQR;
        end else begin
          ph <= ph + 1'b1;
        end
      end
      S_LAST: begin
        // Closing chord to the end point
        seg_x0       <= px;
        seg_y0       <= py;
        seg_x1       <= ex;
        seg_y1       <= ey;
        last_segment <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/dqcs_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on dqcs_pkg for operand and product widths.
`default_nettype none

module dqcs_mul (
  input  logic                                 clk,
  input  dqcs_pkg::mul_op_t                    op,
  output logic signed [dqcs_pkg::PROD_W-1:0]   prod
);
  import dqcs_pkg::*;

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

`default_nettype wire

@@ hw/rtl/dqcs_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on dqcs_pkg for the request and response structs.
`default_nettype none

module dqcs_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  dqcs_pkg::sqrt_req_t req,
  output dqcs_pkg::sqrt_rsp_t rsp
);
  import dqcs_pkg::*;

  localparam int RES_W = SQ_W + 2;
  localparam int K_W   = 5;
  // Highest power of four below 2^SQ_W is 4^(SQ_W/2 - 1)
  localparam logic [K_W-1:0] K_TOP = K_W'(SQ_W / 2 - 1);

  logic [SQ_W-1:0]  rem;
  logic [RES_W-1:0] res;
  logic [K_W-1:0]   k;
  logic             run;
  logic             done;
  logic [RES_W-1:0] bitv;
  logic [RES_W-1:0] trial;

  // Current digit weight and trial subtrahend
  always_comb begin
    bitv  = RES_W'(1) << {k, 1'b0};
    trial = res + bitv;
  end

  // Control: run until the unit digit is done, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
      end else if (run && k == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one compare and subtract per cycle
  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= req.radicand;
      res <= '0;
      k   <= K_TOP;
    end else if (run) begin
      if ({2'b00, rem} >= trial) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      k <= k - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[ROOT_W-1:0];

endmodule

`default_nettype wire
